FILE: sv/i2c_master_register_access_defines.svh
// Assertion macros shared by the I2C register access master.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

// The property must hold at every rising clock edge outside reset.
`define I2CM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/i2cm_pkg.sv
// Package for the I2C register access master: types, codes and helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package i2cm_pkg;

   localparam int COUNT_BITS = 16;

   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic RW_WRITE = 1'b0;
   localparam logic RW_READ  = 1'b1;

   // Last step index of a byte send (8 bits of 3 ticks) and of a byte receive
   // (one release tick, then 8 bits of 3 ticks).
   localparam logic [4:0] SEND_LAST_STEP = 5'd23;
   localparam logic [4:0] RECV_LAST_STEP = 5'd24;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_START,
      PH_SEND,
      PH_ACKR,
      PH_RECV,
      PH_SENDACK,
      PH_STOP_OK,
      PH_STOP_FAIL
   } phase_type;

   typedef enum logic [1:0] {
      ROLE_AW,
      ROLE_REG,
      ROLE_AR,
      ROLE_DATA
   } role_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  reg_number;
      logic [15:0] byte_count;
      logic [7:0]  write_data;
      logic        sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       data_taken;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       done_res;
      logic       success;
   } rsp_type;

   // Remainder of a five-bit value by three through compare and subtract.
   function automatic logic [1:0] mod3(input logic [4:0] value);
      logic [4:0] r;
      r = value;
      if (r >= 5'd24) r = r - 5'd24;
      if (r >= 5'd12) r = r - 5'd12;
      if (r >= 5'd6) r = r - 5'd6;
      if (r >= 5'd3) r = r - 5'd3;
      return r[1:0];
   endfunction

endpackage

FILE: sv/i2cm_seq.sv
// Bus sequencer of the I2C register access master: state registers and the
// per-tick next-state and result logic. Depends on i2cm_pkg and the defines header.
`timescale 1ns / 1ps
`include "i2c_master_register_access_defines.svh"

module i2cm_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  i2cm_pkg::req_type   req,
   input  logic [6:0]          target_address,
   output i2cm_pkg::rsp_type   rsp
);

   i2cm_pkg::phase_type                 phase_ff, phase_in, phase_cur;
   i2cm_pkg::role_type                  role_ff, role_in;
   logic [4:0]                          step_ff, step_in, k;
   logic [7:0]                          shift_ff, shift_in;
   logic [i2cm_pkg::COUNT_BITS-1:0]     left_ff, left_in, left_dec;
   logic [7:0]                          reg_ff, reg_in;
   logic                                read_mode_ff, read_mode_in;
   logic                                scl_pin_ff, scl_pin_in;
   logic                                sda_pin_ff, sda_pin_in;
   logic                                nack_ff, nack_in;
   logic                                repeated_ff, repeated_in;

   logic [i2cm_pkg::COUNT_BITS-1:0]     count;
   logic                                begin_cmd;
   logic                                zero_fail;
   logic                                active;
   logic                                step_wrap;
   logic [1:0]                          recv_sub;
   logic [7:0]                          send_byte;

   logic                                taken;
   logic                                rvalid;
   logic                                done;
   logic                                ok;

   logic                                in_send;
   logic                                in_stop_ok;
   logic                                begin_go;
   logic                                at_start_step1;

   assign count     = req.byte_count[i2cm_pkg::COUNT_BITS-1:0];
   assign begin_cmd = (req.cmd == i2cm_pkg::CMD_WRITE) || (req.cmd == i2cm_pkg::CMD_READ);
   assign left_dec  = left_ff - {{(i2cm_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
   assign recv_sub  = i2cm_pkg::mod3(k - 5'd1);
   assign send_byte = (k == 5'd0 && role_ff == i2cm_pkg::ROLE_DATA) ? req.write_data : shift_ff;

   // A nonzero-count begin command performs its first START tick on the same transaction.
   always_comb begin
      zero_fail = 1'b0;
      active    = 1'b0;
      phase_cur = phase_ff;
      k         = step_ff;
      if (phase_ff == i2cm_pkg::PH_IDLE) begin
         if (begin_cmd) begin
            if (count == '0) begin
               zero_fail = 1'b1;
            end else begin
               active    = 1'b1;
               phase_cur = i2cm_pkg::PH_START;
               k         = 5'd0;
            end
         end
      end else begin
         active = 1'b1;
      end
   end

   // Next state.
   always_comb begin
      phase_in     = phase_ff;
      role_in      = role_ff;
      step_in      = step_ff;
      shift_in     = shift_ff;
      left_in      = left_ff;
      reg_in       = reg_ff;
      read_mode_in = read_mode_ff;
      scl_pin_in   = scl_pin_ff;
      sda_pin_in   = sda_pin_ff;
      nack_in      = nack_ff;
      repeated_in  = repeated_ff;
      step_wrap    = 1'b0;

      if (phase_ff == i2cm_pkg::PH_IDLE && active) begin
         read_mode_in = (req.cmd == i2cm_pkg::CMD_READ);
         reg_in       = req.reg_number;
         left_in      = count;
         repeated_in  = 1'b0;
         nack_in      = 1'b0;
      end

      if (active) begin
         phase_in = phase_cur;
         case (phase_cur)
            i2cm_pkg::PH_START: begin
               if (k == 5'd0) sda_pin_in = 1'b1;
               else if (k == 5'd1) scl_pin_in = 1'b1;
               else if (k == 5'd2) sda_pin_in = 1'b0;
               else begin
                  scl_pin_in = 1'b0;
                  phase_in   = i2cm_pkg::PH_SEND;
                  step_wrap  = 1'b1;
                  if (repeated_ff) begin
                     role_in  = i2cm_pkg::ROLE_AR;
                     shift_in = {target_address, i2cm_pkg::RW_READ};
                  end else begin
                     role_in  = i2cm_pkg::ROLE_AW;
                     shift_in = {target_address, i2cm_pkg::RW_WRITE};
                  end
               end
            end
            i2cm_pkg::PH_SEND: begin
               case (i2cm_pkg::mod3(k))
                  2'd0: begin
                     sda_pin_in = send_byte[7];
                     shift_in   = {send_byte[6:0], 1'b0};
                  end
                  2'd1: scl_pin_in = 1'b1;
                  default: begin
                     scl_pin_in = 1'b0;
                     if (k >= i2cm_pkg::SEND_LAST_STEP) begin
                        phase_in  = i2cm_pkg::PH_ACKR;
                        step_wrap = 1'b1;
                     end
                  end
               endcase
            end
            i2cm_pkg::PH_ACKR: begin
               if (k == 5'd0) sda_pin_in = 1'b1;
               else if (k == 5'd1) scl_pin_in = 1'b1;
               else if (k == 5'd2) nack_in = req.sda_in;
               else begin
                  scl_pin_in = 1'b0;
                  step_wrap  = 1'b1;
                  if (nack_ff) begin
                     phase_in = i2cm_pkg::PH_STOP_FAIL;
                  end else begin
                     case (role_ff)
                        i2cm_pkg::ROLE_AW: begin
                           role_in  = i2cm_pkg::ROLE_REG;
                           shift_in = reg_ff;
                           phase_in = i2cm_pkg::PH_SEND;
                        end
                        i2cm_pkg::ROLE_REG: begin
                           if (read_mode_ff) begin
                              repeated_in = 1'b1;
                              phase_in    = i2cm_pkg::PH_START;
                           end else begin
                              role_in  = i2cm_pkg::ROLE_DATA;
                              shift_in = 8'h00;
                              phase_in = i2cm_pkg::PH_SEND;
                           end
                        end
                        i2cm_pkg::ROLE_AR: begin
                           phase_in = i2cm_pkg::PH_RECV;
                           shift_in = 8'h00;
                        end
                        default: begin
                           left_in = left_dec;
                           if (left_dec == '0) begin
                              phase_in = i2cm_pkg::PH_STOP_OK;
                           end else begin
                              role_in  = i2cm_pkg::ROLE_DATA;
                              shift_in = 8'h00;
                              phase_in = i2cm_pkg::PH_SEND;
                           end
                        end
                     endcase
                  end
               end
            end
            i2cm_pkg::PH_RECV: begin
               if (k == 5'd0) begin
                  // Release SDA so the target can drive the data bits.
                  sda_pin_in = 1'b1;
                  shift_in   = 8'h00;
               end else begin
                  case (recv_sub)
                     2'd0: scl_pin_in = 1'b1;
                     2'd1: shift_in = {shift_ff[6:0], req.sda_in};
                     default: begin
                        scl_pin_in = 1'b0;
                        if (k >= i2cm_pkg::RECV_LAST_STEP) begin
                           phase_in  = i2cm_pkg::PH_SENDACK;
                           step_wrap = 1'b1;
                        end
                     end
                  endcase
               end
            end
            i2cm_pkg::PH_SENDACK: begin
               // The last byte is answered with a NACK.
               if (k == 5'd0) sda_pin_in = (left_ff == {{(i2cm_pkg::COUNT_BITS-1){1'b0}}, 1'b1});
               else if (k == 5'd1) scl_pin_in = 1'b1;
               else begin
                  scl_pin_in = 1'b0;
                  left_in    = left_dec;
                  phase_in   = (left_dec == '0) ? i2cm_pkg::PH_STOP_OK : i2cm_pkg::PH_RECV;
                  step_wrap  = 1'b1;
               end
            end
            i2cm_pkg::PH_STOP_OK, i2cm_pkg::PH_STOP_FAIL: begin
               if (k == 5'd0) sda_pin_in = 1'b0;
               else if (k == 5'd1) scl_pin_in = 1'b1;
               else begin
                  sda_pin_in = 1'b1;
                  phase_in   = i2cm_pkg::PH_IDLE;
                  step_wrap  = 1'b1;
               end
            end
            default: begin
               phase_in  = i2cm_pkg::PH_IDLE;
               step_wrap = 1'b1;
            end
         endcase
         step_in = step_wrap ? 5'd0 : k + 5'd1;
      end
   end

   // Result flags of this tick.
   always_comb begin
      taken  = 1'b0;
      rvalid = 1'b0;
      done   = zero_fail;
      ok     = 1'b0;
      if (active) begin
         case (phase_cur)
            i2cm_pkg::PH_SEND: begin
               taken = (k == 5'd0) && (role_ff == i2cm_pkg::ROLE_DATA);
            end
            i2cm_pkg::PH_RECV: begin
               rvalid = (k >= i2cm_pkg::RECV_LAST_STEP) && (recv_sub == 2'd2);
            end
            i2cm_pkg::PH_STOP_OK: begin
               done = (k >= 5'd2);
               ok   = (k >= 5'd2);
            end
            i2cm_pkg::PH_STOP_FAIL: begin
               done = (k >= 5'd2);
            end
            default: begin
               taken = 1'b0;
            end
         endcase
      end
   end

   assign rsp.scl_level  = scl_pin_in;
   assign rsp.sda_level  = sda_pin_in;
   assign rsp.busy_res   = (phase_in != i2cm_pkg::PH_IDLE);
   assign rsp.data_taken = taken;
   assign rsp.read_byte  = rvalid ? shift_ff : 8'h00;
   assign rsp.read_valid = rvalid;
   assign rsp.done_res   = done;
   assign rsp.success    = done & ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cm_pkg::PH_IDLE;
         role_ff      <= i2cm_pkg::ROLE_AW;
         step_ff      <= 5'd0;
         shift_ff     <= 8'h00;
         left_ff      <= '0;
         reg_ff       <= 8'h00;
         read_mode_ff <= 1'b0;
         scl_pin_ff   <= 1'b1;
         sda_pin_ff   <= 1'b1;
         nack_ff      <= 1'b0;
         repeated_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         role_ff      <= role_in;
         step_ff      <= step_in;
         shift_ff     <= shift_in;
         left_ff      <= left_in;
         reg_ff       <= reg_in;
         read_mode_ff <= read_mode_in;
         scl_pin_ff   <= scl_pin_in;
         sda_pin_ff   <= sda_pin_in;
         nack_ff      <= nack_in;
         repeated_ff  <= repeated_in;
      end
   end

   assign in_send        = (phase_ff == i2cm_pkg::PH_SEND);
   assign in_stop_ok     = (phase_ff == i2cm_pkg::PH_STOP_OK);
   assign begin_go       = accept && (phase_ff == i2cm_pkg::PH_IDLE) && begin_cmd && (count != '0);
   assign at_start_step1 = (phase_ff == i2cm_pkg::PH_START) && (step_ff == 5'd1);

   `I2CM_ASSERT(a_taken_in_send, (accept && taken) |-> in_send, "data taken outside a byte send")
   `I2CM_ASSERT(a_read_in_read_mode, (accept && rvalid) |-> read_mode_ff, "read byte in a write")
   `I2CM_ASSERT(a_success_on_stop, (accept && done && ok) |-> in_stop_ok, "unexpected success")
   `I2CM_ASSERT_NEXT(a_begin_starts, begin_go, at_start_step1, "begin did not enter start")

endmodule

FILE: sv/i2cm_rsp_reg.sv
// Result register of the I2C register access master: holds one packed result
// until the downstream side takes it. Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_rsp_reg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  i2cm_pkg::rsp_type                  rsp_in,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [i2cm_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic                               valid_ff;
   logic [i2cm_pkg::RSP_TDATA_W-1:0]   data_ff, data_in;

   assign data_in = {1'b0, rsp_in.success, rsp_in.done_res, rsp_in.read_valid,
                     rsp_in.read_byte, rsp_in.data_taken, rsp_in.busy_res,
                     rsp_in.sda_level, rsp_in.scl_level};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

FILE: sv/i2c_master_register_access.sv
// Top level of the I2C register access master: configuration register, handshake
// control, sequencer and result register. Depends on i2cm_pkg, i2cm_seq and i2cm_rsp_reg.
//
//   Port group   Direction  Carries
//   req_*        in         one bus tick with command and sampled SDA
//   rsp_*        out        pin levels and status after that tick
//   csr_*        in         seven-bit target address
//
// Every tick is one transaction in and one out; while req_tready is high, a new one
// can be taken each cycle. The whole tick is worked out combinationally between the
// sequencer state and result register, so a result is valid the cycle after acceptance.
// Reset is synchronous and active high; it leaves the bus released and idle.
// req_tready drops only while a result waits in the result register and rsp_tready is low.
`timescale 1ns / 1ps

module i2c_master_register_access (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] reg_number, [23:8] byte_count, [31:24] write_data, [32] sda_in, rest zero
   input  logic [i2cm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] cmd
   input  logic [i2cm_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] scl_level, [1] sda_level, [2] busy_res, [3] data_taken, [11:4] read_byte,
   // [12] read_valid, [13] done_res, [14] success, [15] zero
   output logic [i2cm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_we,
   input  logic [6:0]                         csr_wdata
);

   logic [6:0]           target_addr_ff;
   logic                 accept;
   i2cm_pkg::req_type    req;
   i2cm_pkg::rsp_type    rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_addr_ff <= 7'd0;
      end else if (csr_we) begin
         target_addr_ff <= csr_wdata;
      end
   end

   assign req_tready = ~rsp_tvalid | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   assign req.cmd        = req_tuser;
   assign req.reg_number = req_tdata[7:0];
   assign req.byte_count = req_tdata[23:8];
   assign req.write_data = req_tdata[31:24];
   assign req.sda_in     = req_tdata[32];

   i2cm_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req            (req),
      .target_address (target_addr_ff),
      .rsp            (rsp)
   );

   i2cm_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .rsp_in     (rsp),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
